// ===== rtl/tlbb_pkg.sv =====
package tlbb_pkg;

   // Field widths
   localparam int COORD_W = 12;
   localparam int SIZE_W  = 13;
   localparam int LINE_W  = 16;

   // Hard cap on a frame dimension, set by the coordinate width
   localparam int DIM_CAP = 1 << COORD_W;
   localparam int MAX_DIMENSION_DEFAULT = 4096;

   // Size register reset values
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // One finished text line box
   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [LINE_W-1:0]  line;
   } box_type;

endpackage

// ===== rtl/text_line_bounding_boxes.sv =====
// Text line bounding boxes by horizontal projection.
// Pixels come in on the req_ channel in row-major order, one word per
// handshake; a pixel word of zero is ink. Every maximal run of rows holding
// ink is one text line, and when a blank row or the end of the frame closes
// it a box word (left, top, width, height, line number) leaves on rsp_.
// Frame size is set over csr_: index 0 image width, index 1 image height;
// the user writes it only while no pixel is in flight, as the block does
// not enforce this. csr_ready is always high. Throughput is one pixel per
// clock unless rsp_ stalls: the input register holds the ink flag, the
// row and run tracker updates from it and loads the output register, and
// a box is on rsp_valid once the pixel closing its line has passed both.
// When the receiver stalls with a box waiting, the tracker holds and
// req_ready drops once the input register is full; nothing is lost.
// Reset clears the counters and the open run and sets the frame to 640 x 480.
// Line numbers restart at 1 in every frame.
module text_line_bounding_boxes #(
   parameter int MAX_DIMENSION = tlbb_pkg::MAX_DIMENSION_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [31:0]                  req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tlbb_pkg::COORD_W-1:0] rsp_box_left,
   output logic [tlbb_pkg::COORD_W-1:0] rsp_box_top,
   output logic [tlbb_pkg::SIZE_W-1:0]  rsp_box_width,
   output logic [tlbb_pkg::SIZE_W-1:0]  rsp_box_height,
   output logic [tlbb_pkg::LINE_W-1:0]  rsp_line_number,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  tlbb_pkg::csr_index_type      csr_index,
   input  logic [tlbb_pkg::SIZE_W-1:0]  csr_wdata
);
   import tlbb_pkg::*;

   logic              ink_ff;
   logic              s1_valid_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   box_type           box_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;

   logic              out_free;
   logic              advance;
   logic              emit;
   box_type           box;

   // Pipeline control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: only the ink flag is kept
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ink_ff <= (req_pixel_value == '0);
      end
   end

   tlbb_tracker #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .pixel_ink   (ink_ff),
      .image_width (width_ff),
      .image_height(height_ff),
      .emit        (emit),
      .box         (box)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         box_ff <= box;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_left    = box_ff.left;
   assign rsp_box_top     = box_ff.top;
   assign rsp_box_width   = box_ff.width;
   assign rsp_box_height  = box_ff.height;
   assign rsp_line_number = box_ff.line;

   // A full input register behind a stalled output takes no new word
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while pipeline stalled");

   // A box only appears after the tracker has stepped
   a_box_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("box appeared without a tracker step");

   // Every box spans at least one row and one column
   a_box_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (box_ff.height != '0 && box_ff.width != '0))
      else $error("empty box emitted");

endmodule

// ===== rtl/tlbb_tracker.sv =====
module tlbb_tracker #(
   parameter int MAX_DIMENSION = tlbb_pkg::MAX_DIMENSION_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        pixel_ink,
   input  logic [tlbb_pkg::SIZE_W-1:0] image_width,
   input  logic [tlbb_pkg::SIZE_W-1:0] image_height,
   output logic                        emit,
   output tlbb_pkg::box_type           box
);
   import tlbb_pkg::*;

   localparam int LIMIT = (MAX_DIMENSION > DIM_CAP) ? DIM_CAP : MAX_DIMENSION;
   localparam logic [SIZE_W-1:0] LIMIT_V = SIZE_W'(LIMIT);
   localparam logic [COORD_W-1:0] ALL_ONES = {COORD_W{1'b1}};

   // Last valid index of a size register: zero acts as one, oversize is clamped
   function automatic logic [COORD_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] s;
      s = size;
      if (s == '0) s = SIZE_W'(1);
      if (s > LIMIT_V) s = LIMIT_V;
      s = s - SIZE_W'(1);
      return s[COORD_W-1:0];
   endfunction

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               row_ink_ff, row_ink_in;
   logic [COORD_W-1:0] row_min_ff, row_min_in;
   logic [COORD_W-1:0] row_max_ff, row_max_in;
   logic               in_run_ff, in_run_in;
   logic [COORD_W-1:0] run_top_ff, run_top_in;
   logic [COORD_W-1:0] run_left_ff, run_left_in;
   logic [COORD_W-1:0] run_right_ff, run_right_in;
   logic [LINE_W-1:0]  lines_ff, lines_in;

   logic               row_end;
   logic               frame_end;
   logic               ink_n;
   logic [COORD_W-1:0] min_n;
   logic [COORD_W-1:0] max_n;
   logic [COORD_W-1:0] top_m;
   logic [COORD_W-1:0] left_m;
   logic [COORD_W-1:0] right_m;
   logic [SIZE_W-1:0]  bottom;
   logic [LINE_W-1:0]  line_next;

   // Row summary including the current pixel
   always_comb begin
      row_end   = col_ff >= last_index(image_width);
      frame_end = row_end && (row_ff >= last_index(image_height));
      ink_n     = row_ink_ff | pixel_ink;
      min_n     = (pixel_ink && col_ff < row_min_ff) ? col_ff : row_min_ff;
      max_n     = (pixel_ink && col_ff > row_max_ff) ? col_ff : row_max_ff;
      line_next = lines_ff + LINE_W'(1);
   end

   // Run extent with the finished row merged in
   always_comb begin
      top_m   = run_top_ff;
      left_m  = run_left_ff;
      right_m = run_right_ff;
      if (ink_n) begin
         if (!in_run_ff) begin
            top_m   = row_ff;
            left_m  = min_n;
            right_m = max_n;
         end else begin
            if (min_n < run_left_ff)  left_m  = min_n;
            if (max_n > run_right_ff) right_m = max_n;
         end
      end
   end

   // Next state and box for one pixel
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      row_ink_in   = row_ink_ff;
      row_min_in   = row_min_ff;
      row_max_in   = row_max_ff;
      in_run_in    = in_run_ff;
      run_top_in   = run_top_ff;
      run_left_in  = run_left_ff;
      run_right_in = run_right_ff;
      lines_in     = lines_ff;
      emit         = 1'b0;
      bottom       = {1'b0, row_ff};

      if (step) begin
         if (!row_end) begin
            row_ink_in = ink_n;
            row_min_in = min_n;
            row_max_in = max_n;
            col_in     = col_ff + COORD_W'(1);
         end else begin
            if (ink_n) begin
               in_run_in    = 1'b1;
               run_top_in   = top_m;
               run_left_in  = left_m;
               run_right_in = right_m;
               // a run still open on the last row closes with the frame
               if (frame_end) begin
                  emit     = 1'b1;
                  bottom   = {1'b0, row_ff} + SIZE_W'(1);
                  lines_in = line_next;
               end
            end else if (in_run_ff) begin
               emit         = 1'b1;
               lines_in     = line_next;
               in_run_in    = 1'b0;
               run_left_in  = ALL_ONES;
               run_right_in = '0;
            end

            row_ink_in = 1'b0;
            row_min_in = ALL_ONES;
            row_max_in = '0;
            col_in     = '0;

            if (frame_end) begin
               row_in       = '0;
               in_run_in    = 1'b0;
               run_top_in   = '0;
               run_left_in  = ALL_ONES;
               run_right_in = '0;
               lines_in     = '0;
            end else begin
               row_in = row_ff + COORD_W'(1);
            end
         end
      end
   end

   // Box fields, taken from the run as it stands after this row
   always_comb begin
      box.left   = left_m;
      box.top    = top_m;
      box.width  = '0;
      if (right_m >= left_m)
         box.width = {1'b0, right_m} - {1'b0, left_m} + SIZE_W'(1);
      box.height = bottom - {1'b0, top_m};
      box.line   = line_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         row_ink_ff   <= 1'b0;
         row_min_ff   <= ALL_ONES;
         row_max_ff   <= '0;
         in_run_ff    <= 1'b0;
         run_top_ff   <= '0;
         run_left_ff  <= ALL_ONES;
         run_right_ff <= '0;
         lines_ff     <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_ink_ff   <= row_ink_in;
         row_min_ff   <= row_min_in;
         row_max_ff   <= row_max_in;
         in_run_ff    <= in_run_in;
         run_top_ff   <= run_top_in;
         run_left_ff  <= run_left_in;
         run_right_ff <= run_right_in;
         lines_ff     <= lines_in;
      end
   end

endmodule
